// ===== rtl/gf2n_polynomial_hash_macros.svh =====
// ----------------------------------------------------------------------------
// gf2n_polynomial_hash_macros.svh
// Assertion macros shared by the GF(2^n) polynomial hash RTL.
// ----------------------------------------------------------------------------
`ifndef GF2N_POLYNOMIAL_HASH_MACROS_SVH
`define GF2N_POLYNOMIAL_HASH_MACROS_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define GPH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Whenever ante holds at a clock edge, cons must hold at the next edge.
`define GPH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gph_pkg.sv =====
// ----------------------------------------------------------------------------
// gph_pkg
// Constants, types and the field step function of the GF(2^n) polynomial hash.
// ----------------------------------------------------------------------------
package gph_pkg;

   localparam int KEY_BITS        = 64;
   localparam int VALUE_BITS      = 63;
   localparam int FIELD_BITS_W    = 6;
   localparam int TERMS_W         = 3;
   localparam int MAX_TERMS       = 5;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 64;
   localparam int STEPS_PER_STAGE = 8;
   localparam int STAGES_PER_MUL  = KEY_BITS / STEPS_PER_STAGE;
   localparam int MUL_ROUNDS      = MAX_TERMS - 1;
   localparam int NUM_STAGES      = MUL_ROUNDS * STAGES_PER_MUL;

   localparam logic [FIELD_BITS_W-1:0]  FIELD_BITS_RESET = 6'd32;
   localparam logic [CSR_DATA_BITS-1:0] POLY_RESET       = 64'h0000_0001_0000_008D;
   localparam logic [TERMS_W-1:0]       NUM_TERMS_RESET  = 3'd0;
   localparam logic [TERMS_W-1:0]       MAX_TERMS_CODE   = 3'(MAX_TERMS);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FIELD_BITS,
      REG_REDUCTION_POLY,
      REG_NUM_TERMS,
      REG_COEFF_0,
      REG_COEFF_1,
      REG_COEFF_2,
      REG_COEFF_3,
      REG_COEFF_4
   } csr_index_type;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   // field description derived from field_bits and reduction_poly
   typedef struct packed {
      value_type mask;      // ones below bit n
      value_type low_poly;  // reduction polynomial without the x^n term
      value_type top_sel;   // one-hot at bit n-1, zero when n is zero
   } field_cfg_type;

   typedef struct packed {
      field_cfg_type                        field;
      logic [MAX_TERMS-1:0][VALUE_BITS-1:0] coeff;  // aligned, masked, Horner order
   } cfg_type;

   typedef struct packed {
      key_type   key;  // rotated one byte per stage
      value_type m;    // running multiplicand
      value_type acc;  // partial product
   } stage_type;

   // multiply by x and reduce
   function automatic value_type gf_xtime(value_type m, field_cfg_type f);
      logic top;
      top = |(m & f.top_sel);
      return ((m << 1) & f.mask) ^ (top ? f.low_poly : '0);
   endfunction

endpackage

// ===== rtl/gph_req_if.sv =====
// ----------------------------------------------------------------------------
// gph_req_if
// Key channel: valid/ready handshake carrying one key per item.
// ----------------------------------------------------------------------------
interface gph_req_if;
   logic              valid;
   logic              ready;
   gph_pkg::key_type  key;

   modport source (output valid, output key, input ready);
   modport sink (input valid, input key, output ready);
endinterface

// ===== rtl/gph_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gph_rsp_if
// Hash channel: valid/ready handshake carrying one hash value per item.
// ----------------------------------------------------------------------------
interface gph_rsp_if;
   logic                valid;
   logic                ready;
   gph_pkg::value_type  hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink (input valid, input hash_value, output ready);
endinterface

// ===== rtl/gph_csr.sv =====
// ----------------------------------------------------------------------------
// gph_csr
// Configuration registers and the registered field description derived from
// them: mask, reduced polynomial, top-bit select and aligned coefficients.
// ----------------------------------------------------------------------------
module gph_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  logic [gph_pkg::CSR_INDEX_BITS-1:0]     wr_index,
   input  logic [gph_pkg::CSR_DATA_BITS-1:0]      wr_data,
   output gph_pkg::cfg_type                       cfg
);

   logic [gph_pkg::FIELD_BITS_W-1:0]  field_bits_ff;
   logic [gph_pkg::CSR_DATA_BITS-1:0] poly_ff;
   logic [gph_pkg::TERMS_W-1:0]       terms_ff;
   gph_pkg::value_type                coeff_ff [gph_pkg::MAX_TERMS];

   gph_pkg::cfg_type                  cfg_ff;
   gph_pkg::cfg_type                  cfg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_bits_ff <= gph_pkg::FIELD_BITS_RESET;
         poly_ff       <= gph_pkg::POLY_RESET;
         terms_ff      <= gph_pkg::NUM_TERMS_RESET;
         for (int i = 0; i < gph_pkg::MAX_TERMS; i++) begin
            coeff_ff[i] <= '0;
         end
      end else if (wr_en) begin
         unique case (gph_pkg::csr_index_type'(wr_index))
            gph_pkg::REG_FIELD_BITS:     field_bits_ff <= wr_data[gph_pkg::FIELD_BITS_W-1:0];
            gph_pkg::REG_REDUCTION_POLY: poly_ff       <= wr_data;
            gph_pkg::REG_NUM_TERMS:      terms_ff      <= wr_data[gph_pkg::TERMS_W-1:0];
            gph_pkg::REG_COEFF_0:        coeff_ff[0]   <= wr_data[gph_pkg::VALUE_BITS-1:0];
            gph_pkg::REG_COEFF_1:        coeff_ff[1]   <= wr_data[gph_pkg::VALUE_BITS-1:0];
            gph_pkg::REG_COEFF_2:        coeff_ff[2]   <= wr_data[gph_pkg::VALUE_BITS-1:0];
            gph_pkg::REG_COEFF_3:        coeff_ff[3]   <= wr_data[gph_pkg::VALUE_BITS-1:0];
            gph_pkg::REG_COEFF_4:        coeff_ff[4]   <= wr_data[gph_pkg::VALUE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [gph_pkg::CSR_DATA_BITS-1:0] mask_wide;
      logic [gph_pkg::TERMS_W-1:0]       terms_sat;
      mask_wide = (gph_pkg::CSR_DATA_BITS'(1) << field_bits_ff) - gph_pkg::CSR_DATA_BITS'(1);
      cfg_in.field.mask     = mask_wide[gph_pkg::VALUE_BITS-1:0];
      cfg_in.field.low_poly = poly_ff[gph_pkg::VALUE_BITS-1:0] & cfg_in.field.mask;
      cfg_in.field.top_sel  = cfg_in.field.mask ^ (cfg_in.field.mask >> 1);
      terms_sat = (terms_ff > gph_pkg::MAX_TERMS_CODE) ? gph_pkg::MAX_TERMS_CODE : terms_ff;
      // pad with leading zero coefficients so every item runs all rounds
      for (int j = 0; j < gph_pkg::MAX_TERMS; j++) begin
         cfg_in.coeff[j] = '0;
         for (int i = 0; i < gph_pkg::MAX_TERMS; i++) begin
            if (i + gph_pkg::MAX_TERMS == j + int'(terms_sat)) begin
               cfg_in.coeff[j] = coeff_ff[i] & cfg_in.field.mask;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/gph_stage.sv =====
// ----------------------------------------------------------------------------
// gph_stage
// One pipeline stage of the shift-and-xor multiplier: eight key bits, each
// adding the multiplicand and stepping it by x modulo the polynomial.
// ----------------------------------------------------------------------------
module gph_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  gph_pkg::field_cfg_type field,
   input  logic                   up_valid,
   input  gph_pkg::stage_type     up_data,
   output logic                   up_ready,
   output logic                   dn_valid,
   output gph_pkg::stage_type     dn_data,
   input  logic                   dn_ready
);

   logic               valid_ff;
   logic               valid_in;
   gph_pkg::stage_type data_ff;
   gph_pkg::stage_type data_in;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_comb begin
      gph_pkg::value_type m;
      gph_pkg::value_type acc;
      m   = up_data.m;
      acc = up_data.acc;
      for (int i = 0; i < gph_pkg::STEPS_PER_STAGE; i++) begin
         if (up_data.key[i]) begin
            acc = acc ^ m;
         end
         m = gph_pkg::gf_xtime(m, field);
      end
      data_in.m   = m;
      data_in.acc = acc;
      // rotate the next byte down; the key is whole again after a full multiply
      data_in.key = {up_data.key[gph_pkg::STEPS_PER_STAGE-1:0],
                     up_data.key[gph_pkg::KEY_BITS-1:gph_pkg::STEPS_PER_STAGE]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/gf2n_polynomial_hash.sv =====
// ----------------------------------------------------------------------------
// gf2n_polynomial_hash
// Horner evaluation of a configured polynomial at a 64-bit key in GF(2^n).
// ----------------------------------------------------------------------------
// The block takes one key per cycle while the key channel is ready and returns
// one hash per key, in order, through an input register, 32 multiplier stages
// (four Horner multiplies of 64 key bits, eight bits per stage) and an output
// register. Each stage holds only when the stage after it is full and stalled,
// so bubbles close up and a waiting result does not block new keys while empty
// stages remain. Configuration must be written while no item is in flight; it
// applies to keys accepted once the write has passed through the configuration
// register and the registered field description.
`include "gf2n_polynomial_hash_macros.svh"

module gf2n_polynomial_hash (
   input  logic                               clock,
   input  logic                               reset,
   gph_req_if.sink                            req_chan,
   gph_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [gph_pkg::CSR_INDEX_BITS-1:0] csr_wr_index,
   input  logic [gph_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   localparam int LAST = gph_pkg::NUM_STAGES - 1;

   gph_pkg::cfg_type   cfg;

   logic               in_valid_ff;
   logic               in_valid_in;
   gph_pkg::key_type   in_key_ff;
   logic               in_ready;

   logic               st_up_valid [gph_pkg::NUM_STAGES];
   gph_pkg::stage_type st_up_data  [gph_pkg::NUM_STAGES];
   logic               st_up_ready [gph_pkg::NUM_STAGES];
   logic               st_dn_valid [gph_pkg::NUM_STAGES];
   gph_pkg::stage_type st_dn_data  [gph_pkg::NUM_STAGES];
   logic               st_dn_ready [gph_pkg::NUM_STAGES];

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   gph_pkg::value_type rsp_hash_ff;
   logic               out_ready;

   gph_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr_en),
      .wr_index (csr_wr_index),
      .wr_data  (csr_wr_data),
      .cfg      (cfg)
   );

   // input register
   assign in_ready       = !in_valid_ff || st_up_ready[0];
   assign in_valid_in    = in_ready ? req_chan.valid : in_valid_ff;
   assign req_chan.ready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_key_ff <= req_chan.key;
      end
   end

   for (genvar k = 0; k < gph_pkg::NUM_STAGES; k++) begin : g_stage
      if (k == 0) begin : g_first
         // Horner starts from the first aligned coefficient
         assign st_up_valid[k] = in_valid_ff;
         assign st_up_data[k]  = '{key: in_key_ff, m: cfg.coeff[0], acc: '0};
      end else if (k % gph_pkg::STAGES_PER_MUL == 0) begin : g_round
         // finish a multiply: add the next coefficient, restart the product
         assign st_up_valid[k] = st_dn_valid[k-1];
         assign st_up_data[k]  = '{key: st_dn_data[k-1].key,
                                   m:   st_dn_data[k-1].acc
                                        ^ cfg.coeff[k / gph_pkg::STAGES_PER_MUL],
                                   acc: '0};
      end else begin : g_mid
         assign st_up_valid[k] = st_dn_valid[k-1];
         assign st_up_data[k]  = st_dn_data[k-1];
      end

      if (k == LAST) begin : g_tail
         assign st_dn_ready[k] = out_ready;
      end else begin : g_link
         assign st_dn_ready[k] = st_up_ready[k+1];
      end

      gph_stage u_stage (
         .clock    (clock),
         .reset    (reset),
         .field    (cfg.field),
         .up_valid (st_up_valid[k]),
         .up_data  (st_up_data[k]),
         .up_ready (st_up_ready[k]),
         .dn_valid (st_dn_valid[k]),
         .dn_data  (st_dn_data[k]),
         .dn_ready (st_dn_ready[k])
      );
   end

   // output register
   assign out_ready    = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = out_ready ? st_dn_valid[LAST] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && st_dn_valid[LAST]) begin
         rsp_hash_ff <= st_dn_data[LAST].acc ^ cfg.coeff[gph_pkg::MAX_TERMS-1];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hash_value = rsp_hash_ff;

   `GPH_ASSERT_IMPLY(a_hash_in_field, clock, reset, rsp_chan.valid, (rsp_chan.hash_value & ~cfg.field.mask) == '0, "hash value exceeds field width")
   `GPH_ASSERT_IMPLY(a_zero_coeff_zero_hash, clock, reset, rsp_chan.valid && (cfg.coeff == '0), rsp_chan.hash_value == '0, "nonzero hash with all coefficients zero")
   `GPH_ASSERT_IMPLY(a_ready_low_only_when_full, clock, reset, !req_chan.ready, in_valid_ff, "key channel stalled with empty input register")
   `GPH_ASSERT_NEXT(a_out_taken_when_ready, clock, reset, st_dn_valid[LAST] && out_ready, rsp_chan.valid, "finished item did not reach the output register")

endmodule
